@@ hw/rtl/sosd_pkg.sv @@
// shared types and constants of the sprite opcode stream decoder
package sosd_pkg;

  localparam int MAX_SIDE_DEF = 1024;
  localparam int BYTE_W       = 8;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int PIX_W        = 10;
  localparam int KIND_W       = 2;

  localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(1024);
  localparam logic [PIX_W-1:0] PIX_MAX    = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // command byte codes
  localparam logic [BYTE_W-1:0] CMD_NOP   = 8'd0;
  localparam logic [BYTE_W-1:0] CMD_ROW   = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_END   = 8'd2;
  localparam logic [BYTE_W-1:0] CMD_SKIP  = 8'd3;
  localparam logic [BYTE_W-1:0] CMD_WRITE = 8'd4;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_CMD,
    PH_PIXEL,
    PH_PAD,
    PH_HALT
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_END     = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_OOB     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] stream_byte;
    logic              start_sprite;
  } in_req_t;

endpackage

@@ hw/rtl/sosd_in_if.sv @@
// input byte channel of the sprite decoder
interface sosd_in_if import sosd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              start_sprite;

  modport source (output valid, output stream_byte, output start_sprite, input ready);
  modport sink (input valid, input stream_byte, input start_sprite, output ready);
endinterface

@@ hw/rtl/sosd_out_if.sv @@
// result channel of the sprite decoder
interface sosd_out_if import sosd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PIX_W-1:0]  pixel_x;
  logic [PIX_W-1:0]  pixel_y;
  logic [BYTE_W-1:0] color_index;

  modport source (output valid, output kind, output pixel_x, output pixel_y,
                  output color_index, input ready);
  modport sink (input valid, input kind, input pixel_x, input pixel_y,
                input color_index, output ready);
endinterface

@@ hw/rtl/sosd_cfg_if.sv @@
// configuration write channel of the sprite decoder
interface sosd_cfg_if import sosd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/sosd_in_stage.sv @@
// input register stage of the sprite decoder
module sosd_in_stage import sosd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sosd_in_if.sink   in_ch,
  input  logic      go,
  output logic      s1_valid,
  output in_req_t   s1_req
);

  logic    s1_valid_r;
  in_req_t s1_req_r;

  // the held request leaves whenever the core takes it
  assign in_ch.ready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req_r.stream_byte  <= in_ch.stream_byte;
      s1_req_r.start_sprite <= in_ch.start_sprite;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_req   = s1_req_r;

endmodule

@@ hw/rtl/sosd_core.sv @@
// opcode decode, position state, bounds check and result register
module sosd_core import sosd_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  in_req_t     s1_req,
  output logic        go,
  sosd_cfg_if.sink    cfg_ch,
  sosd_out_if.source  out_ch
);

  localparam int CW   = $clog2(MAX_SIDE + 1);
  localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
  localparam int SW   = ((CW > BYTE_W) ? CW : BYTE_W) + 1;
  localparam logic [SW-1:0]   SAT_MAX  = SW'(MAX_SIDE);
  localparam logic [CMPW-1:0] CLIP_MAX = CMPW'(PIX_MAX);

  logic [CFG_W-1:0] width_r, height_r;

  phase_t            phase_r, phase_nxt, ph_e;
  logic [BYTE_W-1:0] run_r, run_nxt, run_e, run_dec;
  logic [BYTE_W-1:0] held_r, held_nxt, held_e;
  logic [CW-1:0]     column_r, column_nxt, col_e;
  logic [CW-1:0]     row_r, row_nxt, row_e;
  logic              started_r, started_nxt, started_e;
  logic              pad_r, pad_nxt, pad_e;

  logic              emit;
  kind_t             kind_nxt;
  logic [PIX_W-1:0]  x_nxt, y_nxt;
  logic [BYTE_W-1:0] c_nxt;

  logic              out_valid_r;
  kind_t             kind_r;
  logic [PIX_W-1:0]  x_r, y_r;
  logic [BYTE_W-1:0] c_r;

  logic [BYTE_W-1:0] b;
  logic [SW-1:0]     skip_sum, step_sum, row_sum;
  logic [SW-1:0]     skip_sat, step_sat, row_sat;
  logic [CMPW-1:0]   col_ext, row_ext;
  logic              oob;

  assign go = s1_valid && (!out_valid_r || out_ch.ready);
  assign b  = s1_req.stream_byte;

  // configuration is to be written only while idle; the block itself does not enforce this
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_RESET;
      height_r <= SIDE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_WIDTH:  width_r  <= cfg_ch.data;
        REG_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // start of sprite clears the position before the byte is decoded
  always_comb begin
    if (s1_req.start_sprite) begin
      ph_e      = PH_COUNT;
      run_e     = '0;
      held_e    = '0;
      col_e     = '0;
      row_e     = '0;
      started_e = 1'b0;
      pad_e     = 1'b0;
    end else begin
      ph_e      = phase_r;
      run_e     = run_r;
      held_e    = held_r;
      col_e     = column_r;
      row_e     = row_r;
      started_e = started_r;
      pad_e     = pad_r;
    end
  end

  // saturating position arithmetic
  assign skip_sum = SW'(col_e) + SW'(held_e);
  assign step_sum = SW'(col_e) + SW'(1);
  assign row_sum  = SW'(row_e) + SW'(1);
  assign skip_sat = (skip_sum > SAT_MAX) ? SAT_MAX : skip_sum;
  assign step_sat = (step_sum > SAT_MAX) ? SAT_MAX : step_sum;
  assign row_sat  = (row_sum > SAT_MAX) ? SAT_MAX : row_sum;
  assign run_dec  = run_e - BYTE_W'(1);

  assign col_ext = CMPW'(col_e);
  assign row_ext = CMPW'(row_e);
  assign oob = !started_e || (col_ext >= CMPW'(width_r)) || (row_ext >= CMPW'(height_r));

  // next phase
  always_comb begin
    phase_nxt = ph_e;
    unique case (ph_e)
      PH_COUNT: phase_nxt = PH_CMD;
      PH_CMD: begin
        if (b == CMD_WRITE) begin
          phase_nxt = (held_e != '0) ? PH_PIXEL : PH_COUNT;
        end else if (b == CMD_NOP || b == CMD_ROW || b == CMD_SKIP) begin
          phase_nxt = PH_COUNT;
        end else begin
          phase_nxt = PH_HALT;
        end
      end
      PH_PIXEL: begin
        if (run_dec == '0) begin
          phase_nxt = pad_e ? PH_PAD : PH_COUNT;
        end
      end
      PH_PAD:  phase_nxt = PH_COUNT;
      PH_HALT: phase_nxt = PH_HALT;
      default: phase_nxt = PH_HALT;
    endcase
  end

  // datapath updates and result
  always_comb begin
    run_nxt     = run_e;
    held_nxt    = held_e;
    column_nxt  = col_e;
    row_nxt     = row_e;
    started_nxt = started_e;
    pad_nxt     = pad_e;
    emit        = 1'b0;
    kind_nxt    = KIND_PIXEL;
    x_nxt       = '0;
    y_nxt       = '0;
    c_nxt       = '0;
    unique case (ph_e)
      PH_COUNT: held_nxt = b;
      PH_CMD: begin
        unique case (b)
          CMD_NOP: ;
          CMD_ROW: begin
            row_nxt     = started_e ? CW'(row_sat) : '0;
            started_nxt = 1'b1;
            column_nxt  = '0;
          end
          CMD_END: begin
            emit     = 1'b1;
            kind_nxt = KIND_END;
          end
          CMD_SKIP: column_nxt = CW'(skip_sat);
          CMD_WRITE: begin
            if (held_e != '0) begin
              run_nxt = held_e;
              pad_nxt = held_e[0];
            end
          end
          default: begin
            emit     = 1'b1;
            kind_nxt = KIND_INVALID;
            c_nxt    = b;
          end
        endcase
      end
      PH_PIXEL: begin
        emit       = 1'b1;
        kind_nxt   = oob ? KIND_OOB : KIND_PIXEL;
        x_nxt      = (col_ext > CLIP_MAX) ? PIX_MAX : col_ext[PIX_W-1:0];
        y_nxt      = !started_e ? '0 :
                     (row_ext > CLIP_MAX) ? PIX_MAX : row_ext[PIX_W-1:0];
        c_nxt      = b;
        column_nxt = CW'(step_sat);
        run_nxt    = run_dec;
      end
      PH_PAD:  pad_nxt = 1'b0;
      PH_HALT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_COUNT;
      run_r     <= '0;
      held_r    <= '0;
      column_r  <= '0;
      row_r     <= '0;
      started_r <= 1'b0;
      pad_r     <= 1'b0;
    end else if (go) begin
      phase_r   <= phase_nxt;
      run_r     <= run_nxt;
      held_r    <= held_nxt;
      column_r  <= column_nxt;
      row_r     <= row_nxt;
      started_r <= started_nxt;
      pad_r     <= pad_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      kind_r <= kind_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      c_r    <= c_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.pixel_x     = x_r;
  assign out_ch.pixel_y     = y_r;
  assign out_ch.color_index = c_r;

endmodule

@@ hw/rtl/sprite_opcode_stream_decoder.sv @@
// top level of the run-length sprite opcode stream decoder
//
// in_ch takes one byte of the encoded sprite per request; start_sprite on a
// byte marks the count byte of a new sprite and clears position and phase.
// opcodes are two bytes, count then command: no-op, next row, end of
// stream, skip, and write with the pixel bytes (plus a pad byte for an odd
// count) following.
// out_ch gives one request per pixel byte (pixel write or out of bounds)
// and one for end of stream or an invalid command; other bytes give none.
// after end of stream or an invalid command, bytes are dropped until a
// start_sprite byte arrives.
// cfg_ch writes sprite_width (index 0) and sprite_height (index 1); write
// only while the block is idle.
// throughput: one byte per cycle while out_ch is not stalled, set by the
// single decode pass between the input register and the result register.
// each result passes the input register, then the result register, to out_ch.
// reset: phase waits for a count byte, position cleared, width and height
// are 1024, no result pending.
// a stalled receiver holds the result register; one more byte is held in
// the input register, then in_ch.ready drops until the result is taken.
module sprite_opcode_stream_decoder import sosd_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sosd_in_if.sink     in_ch,
  sosd_out_if.source  out_ch,
  sosd_cfg_if.sink    cfg_ch
);

  // handoff between input register and decode stage
  logic    s1_valid;
  in_req_t s1_req;
  logic    go;

  sosd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .go       (go),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  // decode, position counters, bounds check, result register
  sosd_core #(
    .MAX_SIDE (MAX_SIDE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_req   (s1_req),
    .go       (go),
    .cfg_ch   (cfg_ch),
    .out_ch   (out_ch)
  );

endmodule
